// File: rtl/core/assert_macros.svh
// Concurrent assertion helpers shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/pclp_pkg.sv
`default_nettype none

package pclp_pkg;

    localparam int IDX_W      = 7;
    localparam int COORD_W    = 16;
    localparam int CNT_W      = 8;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 56;
    localparam int EV_W       = 3;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_COMMA = 8'h2C;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;

    // keywords left-aligned, first character in the top byte
    localparam logic [39:0] KW_START = "START";
    localparam logic [39:0] KW_END   = {"END", 16'h0000};
    localparam logic [39:0] KW_P     = {"P:", 24'h000000};
    localparam int KW_START_LEN = 5;
    localparam int KW_END_LEN   = 3;
    localparam int KW_P_LEN     = 2;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_START  = 3'd1,
        EV_END    = 3'd2,
        EV_POINT  = 3'd3,
        EV_REJECT = 3'd4,
        EV_READ   = 3'd5
    } ev_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDPT,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT
    } st_t;

    typedef enum logic [2:0] {
        N_XWS,
        N_XSGN,
        N_XDIG,
        N_YWS,
        N_YSGN,
        N_YDIG,
        N_DONE,
        N_FAIL
    } num_st_t;

    typedef struct packed {
        logic                 start_m;
        logic                 end_m;
        logic                 p_m;
        logic                 num_ok;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
    } parse_t;

    function automatic logic [7:0] kw_byte(input logic [39:0] word, input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = word[39:32];
            3'd1:    b = word[31:24];
            3'd2:    b = word[23:16];
            3'd3:    b = word[15:8];
            3'd4:    b = word[7:0];
            default: b = CHR_NUL;
        endcase
        return b;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHR_SPACE) || ((c >= CHR_TAB) && (c <= CHR_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHR_ZERO) && (c <= 8'h39);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pclp_ram.sv
`default_nettype none

module pclp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/pclp_line_parser.sv
`default_nettype none

module pclp_line_parser #(
    parameter int POS_W = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                step,
    input  logic [POS_W-1:0]    pos,
    input  logic [7:0]          chr,
    output pclp_pkg::parse_t    result
);

    import pclp_pkg::*;

    num_st_t              num_st_reg, num_st_next;
    logic                 start_m_reg, start_m_next;
    logic                 end_m_reg, end_m_next;
    logic                 p_m_reg, p_m_next;
    logic                 neg_x_reg, neg_x_next;
    logic                 neg_y_reg, neg_y_next;
    logic [COORD_W-1:0]   acc_x_reg, acc_x_next;
    logic [COORD_W-1:0]   acc_y_reg, acc_y_next;
    logic [7:0]           dig_full;
    logic [COORD_W-1:0]   dig;
    logic [2:0]           p3;
    logic                 in_num;

    assign dig_full = chr - CHR_ZERO;
    assign dig      = COORD_W'(dig_full[3:0]);
    assign p3       = pos[2:0];
    assign in_num   = (pos >= POS_W'(KW_P_LEN));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_st_reg  <= N_XWS;
            start_m_reg <= 1'b0;
            end_m_reg   <= 1'b0;
            p_m_reg     <= 1'b0;
        end
        else
        begin
            num_st_reg  <= num_st_next;
            start_m_reg <= start_m_next;
            end_m_reg   <= end_m_next;
            p_m_reg     <= p_m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_x_reg <= neg_x_next;
        neg_y_reg <= neg_y_next;
        acc_x_reg <= acc_x_next;
        acc_y_reg <= acc_y_next;
    end

    always_comb
    begin
        num_st_next  = num_st_reg;
        start_m_next = start_m_reg;
        end_m_next   = end_m_reg;
        p_m_next     = p_m_reg;
        neg_x_next   = neg_x_reg;
        neg_y_next   = neg_y_reg;
        acc_x_next   = acc_x_reg;
        acc_y_next   = acc_y_reg;

        if (clear)
        begin
            num_st_next  = N_XWS;
            start_m_next = 1'b1;
            end_m_next   = 1'b1;
            p_m_next     = 1'b1;
            neg_x_next   = 1'b0;
            neg_y_next   = 1'b0;
        end
        else if (step)
        begin
            // drop a keyword candidate on its first mismatching character
            if ((pos < POS_W'(KW_START_LEN)) && (chr != kw_byte(KW_START, p3)))
            begin
                start_m_next = 1'b0;
            end
            if ((pos < POS_W'(KW_END_LEN)) && (chr != kw_byte(KW_END, p3)))
            begin
                end_m_next = 1'b0;
            end
            if ((pos < POS_W'(KW_P_LEN)) && (chr != kw_byte(KW_P, p3)))
            begin
                p_m_next = 1'b0;
            end

            if (in_num)
            begin
                case (num_st_reg)
                    N_XWS:
                    begin
                        if (is_digit(chr))
                        begin
                            num_st_next = N_XDIG;
                            acc_x_next  = dig;
                            neg_x_next  = 1'b0;
                        end
                        else if ((chr == CHR_PLUS) || (chr == CHR_MINUS))
                        begin
                            num_st_next = N_XSGN;
                            neg_x_next  = (chr == CHR_MINUS);
                        end
                        else if (!is_blank(chr))
                        begin
                            num_st_next = N_FAIL;
                        end
                    end
                    N_XSGN:
                    begin
                        if (is_digit(chr))
                        begin
                            num_st_next = N_XDIG;
                            acc_x_next  = dig;
                        end
                        else
                        begin
                            num_st_next = N_FAIL;
                        end
                    end
                    N_XDIG:
                    begin
                        if (is_digit(chr))
                        begin
                            acc_x_next = (acc_x_reg << 3) + (acc_x_reg << 1) + dig;
                        end
                        else if (chr == CHR_COMMA)
                        begin
                            num_st_next = N_YWS;
                        end
                        else
                        begin
                            num_st_next = N_FAIL;
                        end
                    end
                    N_YWS:
                    begin
                        if (is_digit(chr))
                        begin
                            num_st_next = N_YDIG;
                            acc_y_next  = dig;
                            neg_y_next  = 1'b0;
                        end
                        else if ((chr == CHR_PLUS) || (chr == CHR_MINUS))
                        begin
                            num_st_next = N_YSGN;
                            neg_y_next  = (chr == CHR_MINUS);
                        end
                        else if (!is_blank(chr))
                        begin
                            num_st_next = N_FAIL;
                        end
                    end
                    N_YSGN:
                    begin
                        if (is_digit(chr))
                        begin
                            num_st_next = N_YDIG;
                            acc_y_next  = dig;
                        end
                        else
                        begin
                            num_st_next = N_FAIL;
                        end
                    end
                    N_YDIG:
                    begin
                        // trailing text after the second value is ignored
                        if (is_digit(chr))
                        begin
                            acc_y_next = (acc_y_reg << 3) + (acc_y_reg << 1) + dig;
                        end
                        else
                        begin
                            num_st_next = N_DONE;
                        end
                    end
                    N_DONE:
                    begin
                        num_st_next = N_DONE;
                    end
                    N_FAIL:
                    begin
                        num_st_next = N_FAIL;
                    end
                    default:
                    begin
                        num_st_next = N_FAIL;
                    end
                endcase
            end
        end
    end

    assign result.start_m = start_m_reg;
    assign result.end_m   = end_m_reg;
    assign result.p_m     = p_m_reg;
    assign result.num_ok  = (num_st_reg == N_YDIG) || (num_st_reg == N_DONE);
    assign result.x       = neg_x_reg ? (COORD_W'(0) - acc_x_reg) : acc_x_reg;
    assign result.y       = neg_y_reg ? (COORD_W'(0) - acc_y_reg) : acc_y_reg;

endmodule

`default_nettype wire

// File: rtl/core/path_command_line_parser_core.sv
// Flow: a buffered byte goes from ST_IDLE to ST_EMIT, a point read through ST_RDPT, and a
// terminator of a non-empty line through ST_SCAN (one line-memory read per cycle over up to
// n characters, n up to LINE_DEPTH-1) and ST_DECIDE; no new item is taken until ST_EMIT
// loads its word into the output register, which holds one finished word. Reset clears the
// line length, point count and path flags; the line and point memories are not cleared,
// and no item is accepted before reset is released.
`default_nettype none

module path_command_line_parser_core #(
    parameter int LINE_DEPTH  = 50,
    parameter int POINT_DEPTH = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pclp_pkg::S_TDATA_W-1:0]     s_tdata,   // rx_byte[7:0], read_index[14:8], pad
    input  logic [0:0]                         s_tuser,   // opcode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // point_index[6:0], coord_x[22:7], coord_y[38:23], stored_points[46:39],
    // path_open[47], path_complete[48], pad
    output logic [pclp_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [pclp_pkg::EV_W-1:0]          m_tuser    // event_res
);

    import pclp_pkg::*;

    localparam int LW   = $clog2(LINE_DEPTH);
    localparam int PA   = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1;
    localparam int PT_W = $clog2(POINT_DEPTH + 1);

    st_t                 state_reg, state_next;
    logic [LW-1:0]       line_len_reg, line_len_next;
    logic [LW-1:0]       pos_reg, pos_next;
    logic [LW-1:0]       len_eff_reg, len_eff_next;
    logic [PT_W-1:0]     point_total_reg, point_total_next;
    logic                recv_reg, recv_next;
    logic                done_reg, done_next;
    ev_t                 res_ev_reg, res_ev_next;
    logic [IDX_W-1:0]    res_slot_reg, res_slot_next;
    logic [COORD_W-1:0]  res_x_reg, res_x_next;
    logic [COORD_W-1:0]  res_y_reg, res_y_next;
    logic                range_reg, range_next;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [EV_W-1:0]     m_tuser_reg;

    logic                s_accept;
    logic                m_load;
    logic [7:0]          rx_byte;
    logic [IDX_W-1:0]    read_index;
    logic                in_range;

    logic                lmem_we, lmem_re;
    logic [LW-1:0]       lmem_ra;
    logic [7:0]          lmem_rd;
    logic                pmem_we, pmem_re;
    logic [31:0]         pmem_rd;

    logic                prs_clear, prs_step;
    parse_t              prs;

    assign rx_byte    = s_tdata[7:0];
    assign read_index = s_tdata[14:8];
    assign in_range   = (32'(read_index) < 32'(POINT_DEPTH));
    assign s_tready   = rst_n && (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;

    pclp_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH),
        .AW    (LW)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (lmem_we),
        .wr_addr (line_len_reg),
        .wr_data (rx_byte),
        .rd_en   (lmem_re),
        .rd_addr (lmem_ra),
        .rd_data (lmem_rd)
    );

    pclp_ram #(
        .WIDTH (32),
        .DEPTH (POINT_DEPTH),
        .AW    (PA)
    ) u_point_ram (
        .clk     (clk),
        .wr_en   (pmem_we),
        .wr_addr (point_total_reg[PA-1:0]),
        .wr_data ({prs.y, prs.x}),
        .rd_en   (pmem_re),
        .rd_addr (PA'(read_index)),
        .rd_data (pmem_rd)
    );

    pclp_line_parser #(
        .POS_W (LW)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (prs_clear),
        .step   (prs_step),
        .pos    (pos_reg),
        .chr    (lmem_rd),
        .result (prs)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            line_len_reg    <= '0;
            point_total_reg <= '0;
            recv_reg        <= 1'b0;
            done_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            line_len_reg    <= line_len_next;
            point_total_reg <= point_total_next;
            recv_reg        <= recv_next;
            done_reg        <= done_next;
            if (m_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        len_eff_reg  <= len_eff_next;
        res_ev_reg   <= res_ev_next;
        res_slot_reg <= res_slot_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        range_reg    <= range_next;
        if (m_load)
        begin
            m_tuser_reg <= res_ev_reg;
            m_tdata_reg <= {7'b0, done_reg, recv_reg, CNT_W'(point_total_reg),
                            res_y_reg, res_x_reg, res_slot_reg};
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        line_len_next    = line_len_reg;
        pos_next         = pos_reg;
        len_eff_next     = len_eff_reg;
        point_total_next = point_total_reg;
        recv_next        = recv_reg;
        done_next        = done_reg;
        res_ev_next      = res_ev_reg;
        res_slot_next    = res_slot_reg;
        res_x_next       = res_x_reg;
        res_y_next       = res_y_reg;
        range_next       = range_reg;
        lmem_we          = 1'b0;
        lmem_re          = 1'b0;
        lmem_ra          = '0;
        pmem_we          = 1'b0;
        pmem_re          = 1'b0;
        prs_clear        = 1'b0;
        prs_step         = 1'b0;
        m_load           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    res_ev_next   = EV_NONE;
                    res_slot_next = '0;
                    res_x_next    = '0;
                    res_y_next    = '0;
                    if (s_tuser[0] == OP_READ)
                    begin
                        pmem_re       = in_range;
                        range_next    = in_range;
                        res_ev_next   = EV_READ;
                        res_slot_next = read_index;
                        state_next    = ST_RDPT;
                    end
                    else if ((rx_byte == CHR_LF) || (rx_byte == CHR_CR))
                    begin
                        if (line_len_reg != '0)
                        begin
                            lmem_re    = 1'b1;
                            pos_next   = '0;
                            prs_clear  = 1'b1;
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                    else if (line_len_reg < LW'(LINE_DEPTH - 1))
                    begin
                        lmem_we       = 1'b1;
                        line_len_next = line_len_reg + 1'b1;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        // overflow: drop the byte and restart the line
                        line_len_next = '0;
                        state_next    = ST_EMIT;
                    end
                end
            end
            ST_RDPT:
            begin
                res_x_next = range_reg ? pmem_rd[15:0] : '0;
                res_y_next = range_reg ? pmem_rd[31:16] : '0;
                state_next = ST_EMIT;
            end
            ST_SCAN:
            begin
                if (lmem_rd == CHR_NUL)
                begin
                    // a zero byte ends the line early
                    len_eff_next = pos_reg;
                    state_next   = ST_DECIDE;
                end
                else
                begin
                    prs_step = 1'b1;
                    if ((pos_reg + 1'b1) == line_len_reg)
                    begin
                        len_eff_next = line_len_reg;
                        state_next   = ST_DECIDE;
                    end
                    else
                    begin
                        lmem_re  = 1'b1;
                        lmem_ra  = pos_reg + 1'b1;
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            ST_DECIDE:
            begin
                line_len_next = '0;
                state_next    = ST_EMIT;
                if (prs.start_m && (len_eff_reg >= LW'(KW_START_LEN)))
                begin
                    point_total_next = '0;
                    recv_next        = 1'b1;
                    done_next        = 1'b0;
                    res_ev_next      = EV_START;
                end
                else if (prs.end_m && (len_eff_reg >= LW'(KW_END_LEN)))
                begin
                    recv_next   = 1'b0;
                    done_next   = 1'b1;
                    res_ev_next = EV_END;
                end
                else if (!(prs.p_m && (len_eff_reg >= LW'(KW_P_LEN))) || !recv_reg
                         || !prs.num_ok || (point_total_reg >= PT_W'(POINT_DEPTH)))
                begin
                    res_ev_next = EV_REJECT;
                end
                else
                begin
                    pmem_we          = 1'b1;
                    point_total_next = point_total_reg + 1'b1;
                    res_ev_next      = EV_POINT;
                    res_slot_next    = IDX_W'(point_total_reg);
                    res_x_next       = prs.x;
                    res_y_next       = prs.y;
                end
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_load     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_line_bound, clk, rst_n, 32'(line_len_reg) <= 32'(LINE_DEPTH - 1))
    `ASSERT_ALWAYS(a_point_bound, clk, rst_n, 32'(point_total_reg) <= 32'(POINT_DEPTH))
    `ASSERT_ALWAYS(a_flags_excl, clk, rst_n, !(recv_reg && done_reg))
    `ASSERT_ALWAYS(a_pmem_no_overlap, clk, rst_n, !(pmem_we && pmem_re))
    `ASSERT_IMPLY(a_scan_in_line, clk, rst_n, state_reg == ST_SCAN, pos_reg < line_len_reg)
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, s_accept, state_reg != ST_IDLE)

endmodule

`default_nettype wire

// File: verif/path_command_line_parser_core_test.sv
module path_command_line_parser_core_test;
    import pclp_pkg::*;

    localparam int LINE_MAX    = 49;
    localparam int POINT_SLOTS = 128;
    localparam logic [7:0] CHR_VT    = 8'h0B;
    localparam logic [7:0] CHR_FF    = 8'h0C;
    localparam logic [7:0] CHR_NINE  = "9";

    typedef struct {
        logic       op;
        logic [7:0] ch;
        logic [6:0] ridx;
    } rx_word_t;

    typedef struct {
        ev_t         ev;
        logic [6:0]  idx;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  cnt;
        logic        path_open;
        logic        path_done;
    } parse_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [EV_W-1:0]      m_tuser;

    path_command_line_parser_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rx_word_t    rx_words[$];
    parse_word_t expected_words[$];
    int          gen_count = 0;
    int          mismatch_count = 0;
    logic        rx_taken = 1'b0;

    // parser state as the block should hold it
    logic [7:0]  line_buf[0:LINE_MAX];
    int          line_len = 0;
    logic [31:0] pt_mem[0:POINT_SLOTS-1];
    int          pt_cnt = 0;
    logic        path_open_f = 1'b0;
    logic        path_done_f = 1'b0;
    int          slots_seen = 0;

    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int mode_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit line_has_kw(input int n, input logic [39:0] kw, input int kw_len);
        if (n < kw_len)
            return 1'b0;
        for (int i = 0; i < kw_len; i++)
            if (line_buf[i] != kw[39 - 8*i -: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    // skip blanks, take an optional sign and a run of digits, wrap to 16 bits
    function automatic bit scan_value(input int n, inout int pos, output logic [15:0] val);
        int p;
        int v;
        bit neg;
        bit any;
        p = pos;
        v = 0;
        neg = 1'b0;
        any = 1'b0;
        val = '0;
        while (p < n && (line_buf[p] == CHR_SPACE ||
                         (line_buf[p] >= CHR_TAB && line_buf[p] <= CHR_CR)))
            p++;
        if (p < n && (line_buf[p] == CHR_PLUS || line_buf[p] == CHR_MINUS))
        begin
            neg = (line_buf[p] == CHR_MINUS);
            p++;
        end
        while (p < n && line_buf[p] >= CHR_ZERO && line_buf[p] <= CHR_NINE)
        begin
            v = (v * 10 + (line_buf[p] - CHR_ZERO)) & 16'hFFFF;
            any = 1'b1;
            p++;
        end
        if (!any)
            return 1'b0;
        val = v[15:0];
        if (neg)
            val = 16'h0000 - val;
        pos = p;
        return 1'b1;
    endfunction

    task automatic parse_and_queue(input logic op, input logic [7:0] ch, input logic [6:0] ridx);
        parse_word_t e;
        int n;
        int pos;
        logic [15:0] xv;
        logic [15:0] yv;
        bit ok;
        e = '{ev: EV_NONE, idx: '0, x: '0, y: '0, cnt: '0, path_open: 1'b0, path_done: 1'b0};
        if (op == OP_READ)
        begin
            e.ev = EV_READ;
            e.idx = ridx;
            e.x = pt_mem[ridx][15:0];
            e.y = pt_mem[ridx][31:16];
        end
        else if (ch == CHR_LF || ch == CHR_CR)
        begin
            if (line_len > 0)
            begin
                // a zero byte cuts the line short
                n = 0;
                while (n < line_len && line_buf[n] != CHR_NUL)
                    n++;
                if (line_has_kw(n, KW_START, KW_START_LEN))
                begin
                    pt_cnt = 0;
                    path_open_f = 1'b1;
                    path_done_f = 1'b0;
                    e.ev = EV_START;
                end
                else if (line_has_kw(n, KW_END, KW_END_LEN))
                begin
                    path_open_f = 1'b0;
                    path_done_f = 1'b1;
                    e.ev = EV_END;
                end
                else
                begin
                    e.ev = EV_REJECT;
                    ok = 1'b0;
                    pos = KW_P_LEN;
                    if (line_has_kw(n, KW_P, KW_P_LEN) && path_open_f)
                        if (scan_value(n, pos, xv))
                            if (pos < n && line_buf[pos] == CHR_COMMA)
                            begin
                                pos++;
                                ok = scan_value(n, pos, yv);
                            end
                    if (ok && pt_cnt < POINT_SLOTS)
                    begin
                        pt_mem[pt_cnt] = {yv, xv};
                        e.ev = EV_POINT;
                        e.idx = pt_cnt[6:0];
                        e.x = xv;
                        e.y = yv;
                        pt_cnt++;
                        if (pt_cnt > slots_seen)
                            slots_seen = pt_cnt;
                    end
                end
            end
            line_len = 0;
        end
        else if (line_len < LINE_MAX)
        begin
            line_buf[line_len] = ch;
            line_len++;
        end
        else
        begin
            // overflow: drop the byte and restart the line
            line_len = 0;
        end
        e.cnt = pt_cnt[7:0];
        e.path_open = path_open_f;
        e.path_done = path_done_f;
        expected_words.push_back(e);
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // input side: accept, predict, note the handshake for the driver
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            parse_and_queue(s_tuser[0], s_tdata[7:0], s_tdata[14:8]);
        rx_taken <= rst_n && s_tvalid && s_tready;
    end

    // output side
    always @(posedge clk)
    begin : result_monitor
        parse_word_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual event %0d data %0h",
                         $time, m_tuser, m_tdata);
                mismatch_count++;
            end
            else
            begin
                e = expected_words.pop_front();
                check_field("event", e.ev, m_tuser);
                check_field("point_index", e.idx, m_tdata[6:0]);
                check_field("coord_x", e.x, m_tdata[22:7]);
                check_field("coord_y", e.y, m_tdata[38:23]);
                check_field("stored_points", e.cnt, m_tdata[46:39]);
                check_field("path_open", e.path_open, m_tdata[47]);
                check_field("path_complete", e.path_done, m_tdata[48]);
            end
        end
    end

    // sender: bursts of words separated by random gaps
    always @(negedge clk)
    begin : byte_driver
        rx_word_t w;
        if (rst_n && (!s_tvalid || rx_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (rx_words.size() != 0)
            begin
                w = rx_words.pop_front();
                s_tdata <= {1'b0, w.ridx, w.ch};
                s_tuser <= w.op;
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: switch between stall patterns every so often
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(20, 200);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic push_item(input logic op, input logic [7:0] ch, input logic [6:0] ridx);
        rx_word_t w;
        w.op = op;
        w.ch = ch;
        w.ridx = ridx;
        rx_words.push_back(w);
        gen_count++;
    endtask

    task automatic push_byte(input logic [7:0] ch);
        push_item(OP_BYTE, ch, $urandom_range(0, 127));
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic end_line();
        push_byte($urandom_range(0, 1) ? CHR_LF : CHR_CR);
    endtask

    task automatic push_blanks();
        repeat ($urandom_range(0, 2))
            case ($urandom_range(0, 3))
                0:       push_byte(CHR_SPACE);
                1:       push_byte(CHR_TAB);
                2:       push_byte(CHR_VT);
                default: push_byte(CHR_FF);
            endcase
    endtask

    task automatic push_number(input int max_digits, input bit with_blanks);
        if (with_blanks)
            push_blanks();
        case ($urandom_range(0, 3))
            0:       push_byte(CHR_PLUS);
            1:       push_byte(CHR_MINUS);
            default: ;
        endcase
        repeat ($urandom_range(1, max_digits))
            push_byte(CHR_ZERO + $urandom_range(0, 9));
    endtask

    task automatic push_letters(input int lo, input int hi);
        repeat ($urandom_range(lo, hi))
            push_byte("a" + $urandom_range(0, 25));
    endtask

    // reads go out only once every earlier word is in, so the written slots are known
    task automatic push_reads(input int k);
        while (rx_words.size() != 0 || s_tvalid)
            @(posedge clk);
        if (slots_seen > 0)
            repeat (k)
                push_item(OP_READ, $urandom_range(0, 255), $urandom_range(0, slots_seen - 1));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed lines
        end_line();
        push_text("P:1,2"); end_line();
        push_text("END"); end_line();
        push_text("HELLO"); end_line();
        push_text("STARTxyz"); end_line();
        push_text("P:");
        push_byte(CHR_SPACE); push_byte(CHR_TAB); push_byte(CHR_VT); push_byte(CHR_FF);
        push_text("+65535,-1 tail"); end_line();
        push_text("P:-0,99999"); end_line();
        push_text("P:1 ,2"); end_line();
        push_text("P:,2"); end_line();
        push_text("P:+,1"); end_line();
        push_text("P:5,"); end_line();
        push_text("P:3,4"); push_byte(CHR_NUL); push_text("zz"); end_line();
        push_text("P:3"); push_byte(CHR_NUL); push_text(",4"); end_line();
        push_text("P:0,0");
        repeat (LINE_MAX - 5) push_byte(CHR_SPACE);
        end_line();
        repeat (LINE_MAX) push_byte("A");
        push_byte("X");
        push_text("P:9,9"); end_line();
        push_text("p:1,2"); end_line();
        push_reads(5);
        push_text("END junk"); end_line();
        push_text("P:1,1"); end_line();
        push_text("START"); end_line();
        push_reads(3);

        // fill the point store past its end
        push_text("START"); end_line();
        repeat (POINT_SLOTS + 3)
        begin
            push_text("P:");
            push_number(1, 1'b0);
            push_byte(CHR_COMMA);
            push_number(1, 1'b0);
            end_line();
        end
        push_reads(16);
        push_item(OP_READ, $urandom_range(0, 255), POINT_SLOTS - 1);

        // mixed traffic, well-formed point lines most often
        while (gen_count < 1300)
        begin : mixed_traffic
            int r;
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                push_text("P:");
                push_number(7, 1'b1);
                push_byte(CHR_COMMA);
                push_number(7, 1'b1);
                if ($urandom_range(0, 3) == 0)
                    push_letters(1, 3);
                end_line();
            end
            else if (r < 55)
            begin
                push_text("P:");
                case ($urandom_range(0, 4))
                    0:
                    begin
                        push_number(5, 1'b1); push_byte(CHR_SPACE);
                        push_byte(CHR_COMMA); push_number(5, 1'b1);
                    end
                    1:
                    begin
                        push_byte(CHR_COMMA); push_number(5, 1'b1);
                    end
                    2:
                    begin
                        push_byte(CHR_MINUS); push_byte(CHR_COMMA); push_number(5, 1'b1);
                    end
                    3:
                    begin
                        push_number(5, 1'b1); push_byte(CHR_COMMA); push_letters(0, 2);
                    end
                    default: push_number(5, 1'b1);
                endcase
                end_line();
            end
            else if (r < 60)
            begin
                push_text("START");
                push_letters(0, 3);
                end_line();
            end
            else if (r < 65)
            begin
                push_text("END");
                push_letters(0, 3);
                end_line();
            end
            else if (r < 72)
            begin
                repeat ($urandom_range(1, 20))
                    push_byte($urandom_range(0, 255));
                end_line();
            end
            else if (r < 75)
                end_line();
            else if (r < 80)
            begin
                // long line that may run past the buffer
                repeat ($urandom_range(45, 60))
                    push_byte($urandom_range(33, 126));
                if ($urandom_range(0, 1))
                begin
                    push_text("P:");
                    push_number(3, 1'b0);
                    push_byte(CHR_COMMA);
                    push_number(3, 1'b0);
                end
                end_line();
            end
            else if (r < 83)
            begin
                push_text("P:");
                push_number(4, 1'b0);
                if ($urandom_range(0, 1))
                begin
                    push_byte(CHR_COMMA); push_number(4, 1'b0); push_byte(CHR_NUL);
                end
                else
                begin
                    push_byte(CHR_NUL); push_byte(CHR_COMMA); push_number(4, 1'b0);
                end
                push_letters(0, 2);
                end_line();
            end
            else
                push_reads($urandom_range(1, 4));
        end

        while (rx_words.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
